// File: src/cce_pkg.sv
package cce_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 64;

   localparam logic [CSR_IDX_W-1:0] CSR_CHUNK_BYTES   = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPECTED_SIZE = 4'd1;

   localparam logic [31:0] CRC_POLY_REFL   = 32'hEDB8_8320;
   localparam logic [31:0] CRC_ALL_ONES    = 32'hFFFF_FFFF;
   localparam logic [31:0] CHUNK_BYTES_RST = 32'd1048576;
   localparam logic [63:0] TOTAL_MAX       = 64'hFFFF_FFFF_FFFF_FFFF;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       byte_valid;
      logic       is_last;
   } req_type;

   typedef struct packed {
      logic        chunk_valid;
      logic [31:0] chunk_index;
      logic [31:0] chunk_crc;
      logic        stream_done;
      logic        size_match;
   } rsp_type;

   function automatic logic [31:0] crc32_byte(input logic [31:0] crc, input logic [7:0] data);
      logic [31:0] c;
      c = crc ^ {24'd0, data};
      for (int k = 0; k < 8; k++) begin
         c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
      end
      return c;
   endfunction

endpackage

// File: src/cce_core.sv
module cce_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                go,
   input  cce_pkg::req_type    req,
   input  logic [31:0]         chunk_bytes,
   input  logic [63:0]         expected_size,
   output logic                push,
   output cce_pkg::rsp_type    rsp
);

   logic [31:0] crc_ff,   crc_in;
   logic [31:0] bytes_ff, bytes_in;
   logic [31:0] count_ff, count_in;
   logic [63:0] total_ff, total_in;

   logic [31:0] crc_next;
   logic [31:0] bytes_inc;
   logic [31:0] bytes_after;
   logic [31:0] limit;
   logic        fill;
   logic        pend;
   logic        have;

   always_comb begin
      limit       = (chunk_bytes == 32'd0) ? 32'd1 : chunk_bytes;
      crc_next    = req.byte_valid ? cce_pkg::crc32_byte(crc_ff, req.data_byte) : crc_ff;
      bytes_inc   = bytes_ff + 32'd1;
      bytes_after = req.byte_valid ? bytes_inc : bytes_ff;
      fill        = req.byte_valid && (bytes_inc >= limit);
      pend        = req.is_last && !fill && (bytes_after != 32'd0);
      have        = fill || pend;
      total_in    = (req.byte_valid && (total_ff != cce_pkg::TOTAL_MAX))
                    ? total_ff + 64'd1 : total_ff;

      push            = go && (have || req.is_last);
      rsp.chunk_valid = have;
      rsp.chunk_index = have ? count_ff : 32'd0;
      rsp.chunk_crc   = have ? ~crc_next : 32'd0;
      rsp.stream_done = req.is_last;
      rsp.size_match  = req.is_last && (total_in == expected_size);

      crc_in   = fill ? cce_pkg::CRC_ALL_ONES : crc_next;
      bytes_in = fill ? 32'd0 : bytes_after;
      count_in = fill ? count_ff + 32'd1 : count_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         crc_ff   <= cce_pkg::CRC_ALL_ONES;
         bytes_ff <= 32'd0;
         count_ff <= 32'd0;
         total_ff <= 64'd0;
      end else if (go) begin
         if (req.is_last) begin
            crc_ff   <= cce_pkg::CRC_ALL_ONES;
            bytes_ff <= 32'd0;
            count_ff <= 32'd0;
            total_ff <= 64'd0;
         end else begin
            crc_ff   <= crc_in;
            bytes_ff <= bytes_in;
            count_ff <= count_in;
            total_ff <= total_in;
         end
      end
   end

endmodule

// File: src/cce_rsp_fifo.sv
module cce_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  cce_pkg::rsp_type   push_data,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output cce_pkg::rsp_type   head
);

   cce_pkg::rsp_type mem_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       cnt_ff,    cnt_in;

   always_comb begin
      full      = (cnt_ff == 2'd2);
      not_empty = (cnt_ff != 2'd0);
      head      = mem_ff[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

endmodule

// File: src/chunked_crc32_engine.sv
// Channel | Direction | Handshake             | Payload
// req     | in        | req_valid / req_ready | data_byte, byte_valid, is_last
// rsp     | out       | rsp_valid / rsp_ready | chunk_valid, chunk_index, chunk_crc,
//         |           |                       | stream_done, size_match
// csr     | in        | csr_wr_en             | csr_index, csr_wdata
//
// One request per cycle unless a full result queue stalls the request register.
// The bytewise CRC-32 update (eight shift/xor steps) sits between the request
// register and a two-entry result queue; that path sets the cycle time.
// Synchronous reset restores CSRs, valid flags, queue pointers and stream state.
// When the queue is full an occupied request register holds and req_ready drops.
module chunked_crc32_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_data_byte,
   input  logic                            req_byte_valid,
   input  logic                            req_is_last,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_chunk_valid,
   output logic [31:0]                     rsp_chunk_index,
   output logic [31:0]                     rsp_chunk_crc,
   output logic                            rsp_stream_done,
   output logic                            rsp_size_match,
   input  logic                            csr_wr_en,
   input  logic [cce_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cce_pkg::CSR_DATA_W-1:0]  csr_wdata
);

   logic [31:0]      chunk_bytes_ff;
   logic [63:0]      expected_size_ff;

   logic             s1_valid_ff;
   cce_pkg::req_type s1_req_ff;
   cce_pkg::req_type req_in;
   logic             s1_go;

   logic             core_push;
   cce_pkg::rsp_type core_rsp;
   logic             q_full;
   logic             q_pop;
   cce_pkg::rsp_type q_head;

   always_ff @(posedge clock) begin
      if (reset) begin
         chunk_bytes_ff   <= cce_pkg::CHUNK_BYTES_RST;
         expected_size_ff <= 64'd0;
      end else if (csr_wr_en) begin
         case (csr_index)
            cce_pkg::CSR_CHUNK_BYTES:   chunk_bytes_ff   <= csr_wdata[31:0];
            cce_pkg::CSR_EXPECTED_SIZE: expected_size_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      req_in.data_byte  = req_data_byte;
      req_in.byte_valid = req_byte_valid;
      req_in.is_last    = req_is_last;
      s1_go             = s1_valid_ff && !q_full;
      req_ready         = !s1_valid_ff || s1_go;
      q_pop             = rsp_valid && rsp_ready;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_valid && req_ready) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         s1_req_ff <= req_in;
      end
   end

   cce_core u_core (
      .clock         (clock),
      .reset         (reset),
      .go            (s1_go),
      .req           (s1_req_ff),
      .chunk_bytes   (chunk_bytes_ff),
      .expected_size (expected_size_ff),
      .push          (core_push),
      .rsp           (core_rsp)
   );

   cce_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (core_push),
      .push_data (core_rsp),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (rsp_valid),
      .head      (q_head)
   );

   assign rsp_chunk_valid = q_head.chunk_valid;
   assign rsp_chunk_index = q_head.chunk_index;
   assign rsp_chunk_crc   = q_head.chunk_crc;
   assign rsp_stream_done = q_head.stream_done;
   assign rsp_size_match  = q_head.size_match;

   a_push_room : assert property (@(posedge clock) disable iff (reset)
      core_push |-> !q_full)
      else $error("result pushed into a full queue");

   a_rsp_nonempty : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_chunk_valid || rsp_stream_done))
      else $error("result carries neither chunk nor end of stream");

   a_match_at_end : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stream_done) |-> !rsp_size_match)
      else $error("size match flagged before end of stream");

   a_empty_chunk : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_chunk_valid) |-> (rsp_chunk_crc == 32'd0 && rsp_chunk_index == 32'd0))
      else $error("chunk fields nonzero without a chunk");

   a_go_after_accept : assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> s1_valid_ff)
      else $error("accepted request lost from the request register");

endmodule

// File: test/crc_chunk_checker.sv
`timescale 1ns / 1ps

module crc_chunk_checker (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   input  logic                           req_ready,
   input  logic [7:0]                     req_data_byte,
   input  logic                           req_byte_valid,
   input  logic                           req_is_last,
   input  logic                           rsp_valid,
   input  logic                           rsp_ready,
   input  logic                           rsp_chunk_valid,
   input  logic [31:0]                    rsp_chunk_index,
   input  logic [31:0]                    rsp_chunk_crc,
   input  logic                           rsp_stream_done,
   input  logic                           rsp_size_match,
   input  logic                           csr_wr_en,
   input  logic [cce_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [cce_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                             outstanding,
   output int                             errors
);

   logic [31:0]      chunk_len_cfg;
   logic [63:0]      expected_total;
   logic [31:0]      run_crc;
   logic [31:0]      fill;
   logic [31:0]      chunk_no;
   logic [63:0]      byte_total;
   cce_pkg::rsp_type crc_results_due[$];
   cce_pkg::rsp_type want;

   function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc, input logic [7:0] b);
      logic [31:0] c;
      c = crc;
      c[7:0] = c[7:0] ^ b;
      repeat (8) c = (c >> 1) ^ (cce_pkg::CRC_POLY_REFL & {32{c[0]}});
      return c;
   endfunction

   task automatic restart_stream();
      run_crc = cce_pkg::CRC_ALL_ONES;
      fill = '0;
      chunk_no = '0;
      byte_total = '0;
   endtask

   task automatic advance_stream(input logic [7:0] b, input logic has_byte, input logic last);
      logic [31:0]      limit;
      cce_pkg::rsp_type r;
      limit = (chunk_len_cfg == '0) ? 32'd1 : chunk_len_cfg;
      r = '0;
      if (has_byte) begin
         run_crc = crc_fold_byte(run_crc, b);
         fill = fill + 32'd1;
         if (byte_total != cce_pkg::TOTAL_MAX) byte_total = byte_total + 64'd1;
         if (fill >= limit) begin
            r.chunk_valid = 1'b1;
            r.chunk_index = chunk_no;
            r.chunk_crc = ~run_crc;
            chunk_no = chunk_no + 32'd1;
            run_crc = cce_pkg::CRC_ALL_ONES;
            fill = '0;
         end
      end
      if (last && !r.chunk_valid && fill != '0) begin
         r.chunk_valid = 1'b1;
         r.chunk_index = chunk_no;
         r.chunk_crc = ~run_crc;
      end
      if (r.chunk_valid || last) begin
         r.stream_done = last;
         r.size_match = last && (byte_total == expected_total);
         crc_results_due.insert(crc_results_due.size(), r);
      end
      if (last) restart_stream();
   endtask

   task automatic note_mismatch(input string field, input logic [31:0] exp_v,
                                input logic [31:0] act_v);
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, exp_v, act_v);
      errors++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         chunk_len_cfg = cce_pkg::CHUNK_BYTES_RST;
         expected_total = '0;
         restart_stream();
         crc_results_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               cce_pkg::CSR_CHUNK_BYTES: chunk_len_cfg = csr_wdata[31:0];
               cce_pkg::CSR_EXPECTED_SIZE: expected_total = csr_wdata;
               default: ;
            endcase
         end
         if (req_valid && req_ready) advance_stream(req_data_byte, req_byte_valid, req_is_last);
         if (rsp_valid && rsp_ready) begin
            if (crc_results_due.size() == 0) begin
               $display("%0t: unexpected result, expected none actual %b/%h/%h %b %b",
                        $time, rsp_chunk_valid, rsp_chunk_index, rsp_chunk_crc,
                        rsp_stream_done, rsp_size_match);
               errors++;
            end else begin
               want = crc_results_due.pop_front();
               if (rsp_chunk_valid !== want.chunk_valid)
                  note_mismatch("chunk_valid", 32'(want.chunk_valid), 32'(rsp_chunk_valid));
               if (rsp_chunk_index !== want.chunk_index)
                  note_mismatch("chunk_index", want.chunk_index, rsp_chunk_index);
               if (rsp_chunk_crc !== want.chunk_crc)
                  note_mismatch("chunk_crc", want.chunk_crc, rsp_chunk_crc);
               if (rsp_stream_done !== want.stream_done)
                  note_mismatch("stream_done", 32'(want.stream_done), 32'(rsp_stream_done));
               if (rsp_size_match !== want.size_match)
                  note_mismatch("size_match", 32'(want.size_match), 32'(rsp_size_match));
            end
         end
      end
      outstanding <= crc_results_due.size();
   end

endmodule

// File: test/tb_chunked_crc32_engine.sv
`timescale 1ns / 1ps

module tb_chunked_crc32_engine;

   localparam int CYCLE_LIMIT = 300000;
   localparam int TARGET_ITEMS = 700;

   logic                           clock;
   logic                           reset = 1'b1;
   logic                           req_valid = 1'b0;
   logic                           req_ready;
   logic [7:0]                     req_data_byte = '0;
   logic                           req_byte_valid = 1'b0;
   logic                           req_is_last = 1'b0;
   logic                           rsp_valid;
   logic                           rsp_ready = 1'b0;
   logic                           rsp_chunk_valid;
   logic [31:0]                    rsp_chunk_index;
   logic [31:0]                    rsp_chunk_crc;
   logic                           rsp_stream_done;
   logic                           rsp_size_match;
   logic                           csr_wr_en = 1'b0;
   logic [cce_pkg::CSR_IDX_W-1:0]  csr_index = cce_pkg::CSR_CHUNK_BYTES;
   logic [cce_pkg::CSR_DATA_W-1:0] csr_wdata = '0;

   int outstanding;
   int errors;
   int cycle_count = 0;
   int sent_items = 0;
   bit req_eager = 1'b0;
   bit rsp_eager = 1'b0;

   chunked_crc32_engine dut (.*);

   crc_chunk_checker checker_i (.*);

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("chunked_crc32_engine regression: fail");
      $finish;
   end

   initial begin
      int stall;
      forever begin
         if ($urandom_range(0, 39) == 0) rsp_eager = !rsp_eager;
         stall = rsp_eager ? 0 : $urandom_range(0, 11);
         if (stall != 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
      end
   end

   task automatic send_req(input logic [7:0] b, input logic has_byte, input logic last);
      int gap;
      gap = req_eager ? 0 : $urandom_range(0, 11);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_byte_valid <= has_byte;
      req_is_last <= last;
      do @(posedge clock); while (!(req_valid && req_ready));
      if (has_byte || last) sent_items++;
   endtask

   // hold off until every result is out, then let the request register empty
   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_phase(input logic [31:0] chunk_len, input logic [63:0] size_goal,
                            input bit stray_write);
      drain_results();
      csr_wr_en <= 1'b1;
      csr_index <= cce_pkg::CSR_CHUNK_BYTES;
      csr_wdata <= {32'($urandom), chunk_len};
      @(posedge clock);
      csr_index <= cce_pkg::CSR_EXPECTED_SIZE;
      csr_wdata <= size_goal;
      @(posedge clock);
      if (stray_write) begin
         csr_index <= cce_pkg::CSR_IDX_W'($urandom_range(cce_pkg::CSR_EXPECTED_SIZE + 1,
                                                          (1 << cce_pkg::CSR_IDX_W) - 1));
         csr_wdata <= {32'($urandom), 32'($urandom)};
         @(posedge clock);
      end
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_stream(input int nbytes, input bit end_on_byte, input int noise_pct);
      for (int i = 0; i < nbytes; i++) begin
         if ($urandom_range(0, 99) < noise_pct) send_req(8'($urandom), 1'b0, 1'b0);
         send_req(8'($urandom), 1'b1, end_on_byte && (i == nbytes - 1));
      end
      if (!(end_on_byte && nbytes > 0)) send_req(8'($urandom), 1'b0, 1'b1);
   endtask

   initial begin
      logic [31:0] chunk_len;
      logic [63:0] size_goal;
      int          stream_len;
      int          noise_pct;
      int          pick;

      repeat (7) @(posedge clock);
      reset <= 1'b0;

      send_req(8'h00, 1'b0, 1'b1);
      send_req(8'hFF, 1'b1, 1'b0);
      send_req(8'h00, 1'b0, 1'b1);

      set_phase(32'd0, 64'd3, 1'b1);
      send_req(8'h00, 1'b1, 1'b0);
      send_req(8'hFF, 1'b1, 1'b0);
      send_req(8'hA5, 1'b1, 1'b1);

      set_phase(32'd9, 64'd10, 1'b0);
      for (int i = 0; i < 9; i++) send_req(8'h31 + 8'(i), 1'b1, 1'b0);
      send_req(8'h00, 1'b0, 1'b0);
      send_req(8'h0A, 1'b1, 1'b0);
      send_req(8'h5A, 1'b0, 1'b1);

      set_phase(32'hFFFF_FFFF, cce_pkg::TOTAL_MAX, 1'b1);
      send_req(8'h80, 1'b1, 1'b0);
      send_req(8'h7F, 1'b1, 1'b0);
      send_req(8'h01, 1'b1, 1'b1);

      while (sent_items < TARGET_ITEMS) begin
         pick = $urandom_range(0, 19);
         if (pick == 0) chunk_len = 32'd0;
         else if (pick == 1) chunk_len = 32'hFFFF_FFFF;
         else if (pick == 2) chunk_len = $urandom;
         else if (pick < 9) chunk_len = $urandom_range(1, 3);
         else chunk_len = $urandom_range(4, 16);
         stream_len = $urandom_range(0, 40);
         pick = $urandom_range(0, 9);
         if (pick < 7) size_goal = 64'(stream_len);
         else if (pick == 7) size_goal = {32'($urandom), 32'($urandom)};
         else if (pick == 8) size_goal = cce_pkg::TOTAL_MAX;
         else size_goal = 64'(stream_len + 1);
         set_phase(chunk_len, size_goal, $urandom_range(0, 3) == 0);
         req_eager = ($urandom_range(0, 3) == 0);
         noise_pct = ($urandom_range(0, 1) == 0) ? 0 : 10;
         repeat ($urandom_range(1, 4)) begin
            send_stream(stream_len, 1'($urandom_range(0, 1)), noise_pct);
            if ($urandom_range(0, 1) == 0) stream_len = $urandom_range(0, 40);
         end
      end

      drain_results();
      repeat (4) @(posedge clock);
      if (errors == 0) begin
         $display("chunked_crc32_engine regression: pass");
      end else begin
         $display("chunked_crc32_engine regression: fail");
      end
      $finish;
   end

endmodule
